// ===== sv/crcd_pkg.sv =====
// ----------------------------------------------------------------------------
// crcd_pkg - cartridge rumble command decoder definitions
// Shared codes, match constants and field widths for the decoder and its
// channel interfaces.
// ----------------------------------------------------------------------------
package crcd_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned DELAY_W = 16;

	// Item kind carried in the action field
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [DELAY_W-1:0] OFF_DELAY_RESET = 16'd200;

	// Bus addresses recognized by the sequencer
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK0 = 32'h09FE_0000;
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK1 = 32'h0800_0000;
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = 32'h0802_0000;
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK3 = 32'h0804_0000;
	localparam logic [ADDR_W-1:0] ADDR_MODE    = 32'h09E2_0000;
	localparam logic [ADDR_W-1:0] ADDR_END     = 32'h09FC_0000;
	localparam logic [ADDR_W-1:0] ADDR_COMMIT  = 32'h0800_1000;

	// Data values recognized by the sequencer
	localparam logic [DATA_W-1:0] DATA_KEY_A   = 16'hD200;
	localparam logic [DATA_W-1:0] DATA_KEY_B   = 16'h1500;
	localparam logic [7:0]        BYTE_NOP     = 8'hF1;
	localparam logic [7:0]        BYTE_HOLD    = 8'h07;
	localparam logic [7:0]        BYTE_PULSE   = 8'h08;
	localparam logic [7:0]        BYTE_CMT_DIR = 8'h00;
	localparam logic [7:0]        BYTE_CMT_HLD = 8'h02;

	typedef enum logic [2:0] {
		SEQ_IDLE    = 3'd0,
		SEQ_UNLOCK1 = 3'd1,
		SEQ_UNLOCK2 = 3'd2,
		SEQ_UNLOCK3 = 3'd3,
		SEQ_UNLOCK4 = 3'd4,
		SEQ_DATA    = 3'd5,
		SEQ_END     = 3'd6
	} seq_state_t;

	typedef enum logic [1:0] {
		MODE_UNSET = 2'd0,
		MODE_PULSE = 2'd1,
		MODE_HOLD  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		EVT_NONE = 2'd0,
		EVT_ON   = 2'd1,
		EVT_OFF  = 2'd2
	} evt_t;

endpackage

// ===== sv/crcd_ifs.sv =====
// ----------------------------------------------------------------------------
// crcd channel interfaces
// Valid/ready channels for decoder input items and result items.
// ----------------------------------------------------------------------------
interface crcd_in_if;
	import crcd_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [ADDR_W-1:0] bus_address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, action, bus_address, write_data, input ready);
	modport sink   (input valid, action, bus_address, write_data, output ready);
endinterface

interface crcd_out_if;
	import crcd_pkg::*;

	logic       valid;
	logic       ready;
	logic       motor_on;
	logic [1:0] drive_event;
	logic [2:0] sequence_step;

	modport source (output valid, motor_on, drive_event, sequence_step, input ready);
	modport sink   (input valid, motor_on, drive_event, sequence_step, output ready);
endinterface

// ===== sv/cart_rumble_command_decoder_top.sv =====
// Order: an input transfer loads the input register; the result register
//   loads from it once it frees (empty, or its result transfers out).
// Throughput: one item per cycle; a new item is taken while a finished
//   result waits, limited only by the two-entry pipeline filling under stall.
// Reset: arst_n clears all control and decoder state at once; the off delay
//   returns to 200 ticks. No clearing pass is needed.
// ----------------------------------------------------------------------------
// cart_rumble_command_decoder_top - cartridge rumble command decoder
// Matches cartridge bus writes against an unlock/command sequence, drives the
// motor level and runs the pulse-mode off countdown on millisecond ticks.
// ----------------------------------------------------------------------------
module cart_rumble_command_decoder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	crcd_in_if.sink                   cmd,
	crcd_out_if.source                rsp,
	input  logic                      cfg_we,
	input  logic [crcd_pkg::DELAY_W-1:0] cfg_wdata
);
	import crcd_pkg::*;

	// Input stage
	logic              valid_s1;
	logic              action_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;

	// Result stage
	logic       rsp_valid_q;
	logic       motor_out_q;
	evt_t       evt_out_q;
	seq_state_t step_out_q;

	// Decoder state
	seq_state_t         seq_q;
	mode_t              mode_q;
	logic               motor_q;
	logic               pend_q;
	logic [DELAY_W-1:0] cnt_q;
	logic [DELAY_W-1:0] delay_q;

	// Next-state values
	seq_state_t         seq_nx;
	mode_t              mode_nx;
	logic               motor_nx;
	logic               pend_nx;
	logic [DELAY_W-1:0] cnt_nx;
	logic [DELAY_W-1:0] cnt_dec;
	evt_t               evt_nx;
	logic               commit;
	logic [7:0]         byte_s1;

	logic rsp_free;
	logic adv_s1;

	// The result register frees when empty or when its item transfers out;
	// the input register, when it holds an item, advances into it whenever it frees.
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign adv_s1    = valid_s1 && rsp_free;
	assign cmd.ready = !valid_s1 || rsp_free;

	assign byte_s1 = data_s1[7:0];

	// Hold the off delay; writes must arrive only while the block is idle (the user's duty; not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= OFF_DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// Capture each transfer into the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= cmd.action;
			addr_s1   <= cmd.bus_address;
			data_s1   <= cmd.write_data;
		end
	end

	// Decode one item against the current state.
	always_comb begin
		seq_nx   = SEQ_IDLE;
		mode_nx  = mode_q;
		motor_nx = motor_q;
		pend_nx  = pend_q;
		cnt_nx   = cnt_q;
		evt_nx   = EVT_NONE;
		commit   = 1'b0;
		cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

		if (action_s1 == ACT_TICK) begin
			// Ticks leave the sequencer alone and run the countdown.
			seq_nx = seq_q;
			if (pend_q) begin
				cnt_nx = cnt_dec;
				if (cnt_dec == '0 && mode_q == MODE_PULSE && motor_q) begin
					motor_nx = 1'b0;
					pend_nx  = 1'b0;
					evt_nx   = EVT_OFF;
				end
			end
		end else begin
			case (seq_q)
				SEQ_IDLE: begin
					if (addr_s1 == ADDR_UNLOCK0 && data_s1 == DATA_KEY_A) begin
						seq_nx = SEQ_UNLOCK1;
					end else if (addr_s1 == ADDR_MODE && byte_s1 == BYTE_PULSE) begin
						mode_nx = MODE_PULSE;
						seq_nx  = SEQ_DATA;
					end else if (addr_s1 == ADDR_COMMIT && byte_s1 == BYTE_CMT_DIR) begin
						// Direct commit without the unlock run
						mode_nx = MODE_PULSE;
						commit  = 1'b1;
					end
				end
				SEQ_UNLOCK1: begin
					if (addr_s1 == ADDR_UNLOCK1 && data_s1 == DATA_KEY_B) seq_nx = SEQ_UNLOCK2;
				end
				SEQ_UNLOCK2: begin
					if (addr_s1 == ADDR_UNLOCK2 && data_s1 == DATA_KEY_A) seq_nx = SEQ_UNLOCK3;
				end
				SEQ_UNLOCK3: begin
					if (addr_s1 == ADDR_UNLOCK3 && data_s1 == DATA_KEY_B) seq_nx = SEQ_UNLOCK4;
				end
				SEQ_UNLOCK4: begin
					if (addr_s1 == ADDR_MODE) begin
						if (byte_s1 == BYTE_NOP) begin
							seq_nx = SEQ_DATA;
						end else if (byte_s1 == BYTE_HOLD) begin
							mode_nx = MODE_HOLD;
							seq_nx  = SEQ_DATA;
						end else if (byte_s1 == BYTE_PULSE) begin
							mode_nx = MODE_PULSE;
							seq_nx  = SEQ_DATA;
						end
					end
				end
				SEQ_DATA: begin
					if (addr_s1 == ADDR_END && data_s1 == DATA_KEY_B) seq_nx = SEQ_END;
				end
				SEQ_END: begin
					if (addr_s1 == ADDR_COMMIT) begin
						mode_nx = (byte_s1 == BYTE_CMT_HLD) ? MODE_HOLD : MODE_PULSE;
						commit  = 1'b1;
					end
				end
				default: begin
					seq_nx = SEQ_IDLE;
				end
			endcase

			// Apply a commit under the mode just chosen; unset mode drops it.
			if (commit && (mode_nx == MODE_HOLD || mode_nx == MODE_PULSE)) begin
				if (mode_nx == MODE_HOLD) begin
					pend_nx = 1'b0;
					cnt_nx  = '0;
				end else begin
					pend_nx = 1'b1;
					cnt_nx  = delay_q;
				end
				motor_nx = 1'b1;
				evt_nx   = motor_q ? EVT_NONE : EVT_ON;
			end
		end
	end

	// Advance decoder state as the item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= SEQ_IDLE;
			mode_q  <= MODE_UNSET;
			motor_q <= 1'b0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (adv_s1) begin
			seq_q   <= seq_nx;
			mode_q  <= mode_nx;
			motor_q <= motor_nx;
			pend_q  <= pend_nx;
			cnt_q   <= cnt_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			motor_out_q <= motor_nx;
			evt_out_q   <= evt_nx;
			step_out_q  <= seq_nx;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.motor_on      = motor_out_q;
	assign rsp.drive_event   = evt_out_q;
	assign rsp.sequence_step = step_out_q;

	// A pending off implies the motor is running.
	a_pend_motor: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> motor_q)
		else $error("off pending with motor off");

	// Ticks never move the sequencer.
	a_tick_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && action_s1 == ACT_TICK) |=> $stable(seq_q))
		else $error("tick changed sequencer state");

	// A switch-on result reports the motor on, a switch-off result reports it off.
	a_evt_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((evt_out_q == EVT_ON && motor_out_q)
			|| (evt_out_q == EVT_OFF && !motor_out_q) || evt_out_q == EVT_NONE))
		else $error("drive event disagrees with motor level");

	// Decoder state only moves when an item advances.
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(motor_q) && $stable(cnt_q) && $stable(mode_q)))
		else $error("decoder state moved without an item");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - rumble command decoder testbench
// Sends cartridge bus writes and millisecond ticks to the decoder. A model of
// its own predicts motor level, drive event and sequencer step for every
// transfer, and each result is checked against it in order. The stimulus
// opens with directed unlock, commit and countdown cases. Random command
// runs, tick bursts and bus noise follow under several off delays and
// sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import crcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic       motor_on;
		evt_t       drive_event;
		seq_state_t sequence_step;
	} drive_result_t;

	// Addresses the sequencer knows, for writes with random data
	localparam logic [ADDR_W-1:0] KNOWN_ADDRS [7] = '{
		ADDR_UNLOCK0, ADDR_UNLOCK1, ADDR_UNLOCK2, ADDR_UNLOCK3,
		ADDR_MODE, ADDR_END, ADDR_COMMIT
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [DELAY_W-1:0] cfg_wdata;

	crcd_in_if  cmd_if ();
	crcd_out_if rsp_if ();

	cart_rumble_command_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Decoder model state, updated once per accepted transfer
	seq_state_t         pm_seq;
	mode_t              pm_mode;
	logic               pm_motor;
	logic               pm_pending;
	logic [DELAY_W-1:0] pm_count;
	logic [DELAY_W-1:0] pm_delay;

	drive_result_t expected_results [$];

	int unsigned items_sent;
	int unsigned error_count;
	int unsigned on_seen;
	int unsigned off_seen;
	int unsigned cycle_count;
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned step_break_pct;

	// Free-running clock, 4 ns period
	always #2 clk = ~clk;

	// Apply a commit in the current mode; hold cancels the off, pulse arms it
	function automatic evt_t motor_commit();
		logic was_on;
		was_on = pm_motor;
		case (pm_mode)
			MODE_HOLD: begin
				pm_pending = 1'b0;
				pm_count   = '0;
			end
			MODE_PULSE: begin
				pm_pending = 1'b1;
				pm_count   = pm_delay;
			end
			default: return EVT_NONE;
		endcase
		pm_motor = 1'b1;
		return was_on ? EVT_NONE : EVT_ON;
	endfunction

	// Advance the model by one item and return the result it should produce
	function automatic drive_result_t predict_drive(input logic act,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		drive_result_t res;
		evt_t          ev;
		seq_state_t    nxt;
		ev = EVT_NONE;
		if (act == ACT_TICK) begin
			// Ticks touch only the countdown; the sequencer holds its state
			if (pm_pending) begin
				if (pm_count != '0)
					pm_count = pm_count - 1'b1;
				if (pm_count == '0 && pm_mode == MODE_PULSE && pm_motor) begin
					pm_motor   = 1'b0;
					pm_pending = 1'b0;
					ev         = EVT_OFF;
				end
			end
		end else begin
			// Any write that fails to match drops the sequencer back to idle
			nxt = SEQ_IDLE;
			case (pm_seq)
				SEQ_IDLE: begin
					if (addr == ADDR_UNLOCK0 && data == DATA_KEY_A) begin
						nxt = SEQ_UNLOCK1;
					end else if (addr == ADDR_MODE && data[7:0] == BYTE_PULSE) begin
						pm_mode = MODE_PULSE;
						nxt     = SEQ_DATA;
					end else if (addr == ADDR_COMMIT && data[7:0] == BYTE_CMT_DIR) begin
						pm_mode = MODE_PULSE;
						ev      = motor_commit();
					end
				end
				SEQ_UNLOCK1: if (addr == ADDR_UNLOCK1 && data == DATA_KEY_B) nxt = SEQ_UNLOCK2;
				SEQ_UNLOCK2: if (addr == ADDR_UNLOCK2 && data == DATA_KEY_A) nxt = SEQ_UNLOCK3;
				SEQ_UNLOCK3: if (addr == ADDR_UNLOCK3 && data == DATA_KEY_B) nxt = SEQ_UNLOCK4;
				SEQ_UNLOCK4: begin
					if (addr == ADDR_MODE) begin
						if (data[7:0] == BYTE_NOP) begin
							nxt = SEQ_DATA;
						end else if (data[7:0] == BYTE_HOLD) begin
							pm_mode = MODE_HOLD;
							nxt     = SEQ_DATA;
						end else if (data[7:0] == BYTE_PULSE) begin
							pm_mode = MODE_PULSE;
							nxt     = SEQ_DATA;
						end
					end
				end
				SEQ_DATA: if (addr == ADDR_END && data == DATA_KEY_B) nxt = SEQ_END;
				SEQ_END: begin
					if (addr == ADDR_COMMIT) begin
						pm_mode = (data[7:0] == BYTE_CMT_HLD) ? MODE_HOLD : MODE_PULSE;
						ev      = motor_commit();
					end
				end
				default: nxt = SEQ_IDLE;
			endcase
			pm_seq = nxt;
		end
		res.motor_on      = pm_motor;
		res.drive_event   = ev;
		res.sequence_step = pm_seq;
		return res;
	endfunction

	// Send one item: idle at random first, then hold valid until the transfer.
	// Enter and leave at a falling edge with nothing yet driven in that step.
	task automatic push_bus_item(input logic act, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid       <= 1'b1;
		cmd_if.action      <= act;
		cmd_if.bus_address <= addr;
		cmd_if.write_data  <= data;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		expected_results.push_back(predict_drive(act, addr, data));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic bus_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		push_bus_item(ACT_WRITE, addr, data);
	endtask

	// Ticks carry random address and data, which the decoder must ignore
	task automatic ms_tick();
		push_bus_item(ACT_TICK, $urandom, 16'($urandom));
	endtask

	// Write one step of a command run; break it now and then
	task automatic seq_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		a = addr;
		d = data;
		if ($urandom_range(99) < step_break_pct) begin
			if ($urandom_range(1))
				a = $urandom;
			else
				d = 16'($urandom);
		end
		bus_write(a, d);
	endtask

	// Four unlock writes followed by the mode write
	task automatic unlock_run(input logic [7:0] mode_byte);
		seq_write(ADDR_UNLOCK0, DATA_KEY_A);
		seq_write(ADDR_UNLOCK1, DATA_KEY_B);
		seq_write(ADDR_UNLOCK2, DATA_KEY_A);
		seq_write(ADDR_UNLOCK3, DATA_KEY_B);
		seq_write(ADDR_MODE, {8'($urandom), mode_byte});
	endtask

	// End write, then the commit; its low byte picks hold or pulse
	task automatic finish_command(input logic [7:0] commit_byte);
		seq_write(ADDR_END, DATA_KEY_B);
		seq_write(ADDR_COMMIT, {8'($urandom), commit_byte});
	endtask

	// Drop valid and wait until every result is back
	task automatic drain_pipeline();
		cmd_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the off delay only while the decoder is idle
	task automatic write_delay_reg(input logic [DELAY_W-1:0] value);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		pm_delay  = value;
	endtask

	// Full unlock into hold, then a direct pulse commit on a motor that is on
	task automatic test_unlock_hold();
		unlock_run(BYTE_HOLD);
		finish_command(BYTE_CMT_HLD);
		// Already on: the pulse arms the reset delay but reports no event
		bus_write(ADDR_COMMIT, {8'hFF, BYTE_CMT_DIR});
		push_bus_item(ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF);
		push_bus_item(ACT_TICK, 32'h0000_0000, 16'h0000);
		bus_write(32'hFFFF_FFFF, 16'hFFFF);
		bus_write(32'h0000_0000, 16'h0000);
	endtask

	task automatic test_special_cases();
		// One-tick delay: pulse commit, off on the next tick
		write_delay_reg(16'd1);
		bus_write(ADDR_COMMIT, {8'h00, BYTE_CMT_DIR});
		ms_tick();
		// Zero delay: the off still waits for the first tick
		write_delay_reg(16'd0);
		bus_write(ADDR_COMMIT, {8'h5A, BYTE_CMT_DIR});
		ms_tick();
		// Countdown runs out in hold mode, stays armed, fires once pulse returns
		write_delay_reg(16'd1);
		bus_write(ADDR_COMMIT, {8'h00, BYTE_CMT_DIR});
		unlock_run(BYTE_HOLD);
		ms_tick();
		ms_tick();
		bus_write(32'h0000_0000, 16'h0000);
		bus_write(ADDR_MODE, {8'hC3, BYTE_PULSE});
		ms_tick();
	endtask

	// Random traffic: command runs with random content, direct commits, tick bursts, some noise
	task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [DELAY_W-1:0] delay, input int unsigned count);
		int unsigned goal;
		int unsigned pick;
		int unsigned burst_max;
		logic [7:0]  mb;
		write_delay_reg(delay);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		step_break_pct     = 6;
		burst_max = (pm_delay > 16'd12) ? 14 : int'(pm_delay) + 3;
		goal      = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				case ($urandom_range(3))
					0:       mb = BYTE_NOP;
					1:       mb = BYTE_HOLD;
					2:       mb = BYTE_PULSE;
					default: mb = 8'($urandom);
				endcase
				unlock_run(mb);
				finish_command($urandom_range(1) ? BYTE_CMT_HLD : 8'($urandom));
			end else if (pick < 40) begin
				seq_write(ADDR_MODE, {8'($urandom), BYTE_PULSE});
				finish_command($urandom_range(1) ? BYTE_CMT_HLD : 8'($urandom));
			end else if (pick < 50) begin
				bus_write(ADDR_COMMIT, {8'($urandom), BYTE_CMT_DIR});
			end else if (pick < 78) begin
				repeat ($urandom_range(1, burst_max)) ms_tick();
			end else if (pick < 90) begin
				bus_write($urandom, 16'($urandom));
			end else begin
				bus_write(KNOWN_ADDRS[$urandom_range(6)], 16'($urandom));
			end
		end
	endtask

	// Receiver: stall at random, decided at each falling edge
	always @(negedge clk) begin
		if (arst_n)
			rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_monitor
		drive_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no prediction waiting");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (rsp_if.motor_on !== want.motor_on) begin
					$error("motor_on: expected %0d, got %0d", want.motor_on, rsp_if.motor_on);
					error_count++;
				end
				if (rsp_if.drive_event !== want.drive_event) begin
					$error("drive_event: expected %0d, got %0d", want.drive_event,
						rsp_if.drive_event);
					error_count++;
				end
				if (rsp_if.sequence_step !== want.sequence_step) begin
					$error("sequence_step: expected %0d, got %0d", want.sequence_step,
						rsp_if.sequence_step);
					error_count++;
				end
				if (want.drive_event == EVT_ON)
					on_seen++;
				if (want.drive_event == EVT_OFF)
					off_seen++;
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		cmd_if.valid       = 1'b0;
		cmd_if.action      = ACT_WRITE;
		cmd_if.bus_address = '0;
		cmd_if.write_data  = '0;
		rsp_if.ready       = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		step_break_pct     = 0;
		items_sent         = 0;
		error_count        = 0;
		on_seen            = 0;
		off_seen           = 0;
		cycle_count        = 0;
		// Model reset state
		pm_seq     = SEQ_IDLE;
		pm_mode    = MODE_UNSET;
		pm_motor   = 1'b0;
		pm_pending = 1'b0;
		pm_count   = '0;
		pm_delay   = OFF_DELAY_RESET;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unlock_hold();
		test_special_cases();
		test_random_phase(0, 0, 16'd0, 330);
		test_random_phase(75, 0, 16'($urandom_range(1, 8)), 330);
		test_random_phase(0, 75, 16'hFFFF, 330);
		test_random_phase(24, 24, 16'($urandom_range(2, 20)), 330);

		// Let the pipeline empty, then watch for stray results
		drain_pipeline();
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d predicted results never arrived", expected_results.size());
			error_count++;
		end

		$display("tb_top: %0d items sent over four idle/stall mixes and off delays 0..65535",
			items_sent);
		$display("tb_top: %0d motor-on and %0d motor-off events checked, %0d mismatches",
			on_seen, off_seen, error_count);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
